// ----- sv/rcts_pkg.sv -----
// Shared types and constants for the raycast column texture stepper.
// No dependencies; every other file imports this package.
package rcts_pkg;

    localparam int SCREEN_HEIGHT_DEF = 480;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int COL_W      = 12;
    localparam int ROW_W      = 12;
    localparam int SIDE_W     = 2;
    localparam int DIST_W     = 24;
    localparam int DIR_W      = 16;
    localparam int DIR_FRAC   = 14;
    localparam int POS_W      = 24;
    localparam int COLOR_W    = 24;
    localparam int TEXW_W     = 11;
    localparam int HLOG2_W    = 4;
    localparam int TEXEL_W    = 10;
    localparam int FIX_W      = 32;
    localparam int LH_W       = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int TEX_WIDTH_MAX = 1024;
    localparam int TEX_WIDTH_RST = 64;
    localparam int TEX_HLOG2_MAX = 10;
    localparam int TEX_HLOG2_RST = 6;

    localparam int Q_DEPTH = 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_ROW  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        KIND_CEILING = 2'd0,
        KIND_WALL    = 2'd1,
        KIND_FLOOR   = 2'd2
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CEILING   = 2'd0,
        REG_FLOOR     = 2'd1,
        REG_TEX_WIDTH = 2'd2,
        REG_TEX_HLOG2 = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        FS_IDLE,
        FS_PROD,
        FS_FRAC,
        FS_TXMUL,
        FS_TXFIX,
        FS_LHWAIT,
        FS_LHFIX,
        FS_STEPWAIT,
        FS_POSMUL,
        FS_PUSH
    } front_state_t;

    // texture width and height log2 are held already saturated
    typedef struct packed {
        logic [COLOR_W-1:0] ceiling_color;
        logic [COLOR_W-1:0] floor_color;
        logic [TEXW_W-1:0]  tex_width;
        logic [HLOG2_W-1:0] tex_hlog2;
    } cfg_t;

    typedef struct packed {
        op_t               op;
        logic [COL_W-1:0]  column;
        logic [SIDE_W-1:0] side;
        logic [TEXEL_W-1:0] texel_x;
        logic [ROW_W-1:0]  first_row;
        logic [ROW_W-1:0]  end_row;
        logic [FIX_W-1:0]  step;
        logic [FIX_W-1:0]  tpos;
    } entry_t;

    typedef struct packed {
        logic               valid_res;
        logic [COL_W-1:0]   pixel_column;
        logic [ROW_W-1:0]   pixel_row;
        kind_t              pixel_kind;
        logic [COLOR_W-1:0] solid_color;
        logic [SIDE_W-1:0]  texture_select;
        logic [TEXEL_W-1:0] texel_x;
        logic [TEXEL_W-1:0] texel_y;
        logic               last_row;
    } pix_t;

endpackage

// ----- sv/rcts_channels.sv -----
// Valid/ready channel interfaces: column/row requests in, pixels out.
// Depends on rcts_pkg.
interface rcts_cmd_if;
    import rcts_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic [COL_W-1:0]         column_x;
    logic [SIDE_W-1:0]        hit_side;
    logic [DIST_W-1:0]        wall_distance;
    logic signed [DIR_W-1:0]  ray_dx;
    logic signed [DIR_W-1:0]  ray_dy;
    logic [POS_W-1:0]         player_x;
    logic [POS_W-1:0]         player_y;

    modport source (
        output valid, opcode, column_x, hit_side, wall_distance,
               ray_dx, ray_dy, player_x, player_y,
        input  ready
    );
    modport sink (
        input  valid, opcode, column_x, hit_side, wall_distance,
               ray_dx, ray_dy, player_x, player_y,
        output ready
    );
endinterface

interface rcts_pix_if;
    import rcts_pkg::*;

    logic               valid;
    logic               ready;
    logic               valid_res;
    logic [COL_W-1:0]   pixel_column;
    logic [ROW_W-1:0]   pixel_row;
    logic [1:0]         pixel_kind;
    logic [COLOR_W-1:0] solid_color;
    logic [SIDE_W-1:0]  texture_select;
    logic [TEXEL_W-1:0] texel_x;
    logic [TEXEL_W-1:0] texel_y;
    logic               last_row;

    modport source (
        output valid, valid_res, pixel_column, pixel_row, pixel_kind,
               solid_color, texture_select, texel_x, texel_y, last_row,
        input  ready
    );
    modport sink (
        input  valid, valid_res, pixel_column, pixel_row, pixel_kind,
               solid_color, texture_select, texel_x, texel_y, last_row,
        output ready
    );
endinterface

// ----- sv/rcts_divider.sv -----
// Restoring divider, one quotient bit per cycle, 24-bit divisor.
// Depends on rcts_pkg. Division by zero returns all ones.
module rcts_divider #(
    parameter int NUM_W = 27
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [NUM_W-1:0]              numer,
    input  logic [rcts_pkg::DIST_W-1:0]   denom,
    output logic                          done,
    output logic [NUM_W-1:0]              quot
);
    import rcts_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NUM_W-1:0]  num_reg;
    logic [DIST_W-1:0] rem_reg;
    logic [DIST_W-1:0] den_reg;

    logic [DIST_W:0]   rem_shift;
    logic [DIST_W+1:0] diff;
    logic              qbit;

    assign rem_shift = {rem_reg, num_reg[NUM_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign qbit      = ~diff[DIST_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= numer;
            den_reg <= denom;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], qbit};
            rem_reg <= qbit ? diff[DIST_W-1:0] : rem_shift[DIST_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

// ----- sv/rcts_front.sv -----
// Front end: takes requests, passes row ticks straight to the queue and
// works out a column descriptor for each load. Depends on rcts_pkg, rcts_divider.
module rcts_front #(
    parameter int SCREEN_HEIGHT = rcts_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRACTION_BITS = rcts_pkg::FRACTION_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    rcts_cmd_if.sink          cmd,
    input  rcts_pkg::cfg_t    cfg,
    output logic              q_wr_valid,
    input  logic              q_wr_ready,
    output rcts_pkg::entry_t  q_wr_entry
);
    import rcts_pkg::*;

    localparam int SH_W    = $clog2(SCREEN_HEIGHT + 1);
    localparam int STEP_IW = TEX_HLOG2_MAX + 1;
    localparam int NUM_W   = ((SH_W > STEP_IW) ? SH_W : STEP_IW) + FRACTION_BITS;
    localparam int WC_W    = DIR_FRAC + FRACTION_BITS;
    localparam int PROD_W  = DIST_W + DIR_W;
    localparam int H_HALF  = SCREEN_HEIGHT / 2;
    localparam int TXP_W   = FRACTION_BITS + TEXW_W;
    localparam int HALF_W  = LH_W - 1;
    localparam int PMUL_W  = HALF_W + FIX_W;

    front_state_t state_reg, state_next;

    logic [COL_W-1:0]        col_reg;
    logic [SIDE_W-1:0]       side_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic [POS_W-1:0]        wpos_reg;
    logic signed [DIR_W-1:0] dir_reg;
    logic                    mirror_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [FRACTION_BITS-1:0] frac_reg;
    logic [TXP_W-1:0]        txp_reg;
    logic [TEXEL_W-1:0]      texel_reg;
    logic [LH_W-1:0]         lh_reg;
    logic [ROW_W-1:0]        first_reg;
    logic [ROW_W-1:0]        end_reg;
    logic [HALF_W-1:0]       off_reg;
    logic [FIX_W-1:0]        step_reg;
    logic [FIX_W-1:0]        tpos_reg;

    logic                    in_ready;
    logic                    load_acc;
    logic                    div_start;
    logic [NUM_W-1:0]        div_num;
    logic [DIST_W-1:0]       div_den;
    logic                    div_done;
    logic [NUM_W-1:0]        div_quot;
    logic [63:0]             quot_ext;
    logic [NUM_W-1:0]        lh_num;
    logic [NUM_W-1:0]        step_num;

    logic signed [PROD_W:0]  prod_c;
    logic [WC_W-1:0]         wc_sum;
    logic [TEXW_W-1:0]       tx_raw;
    logic [TEXW_W-1:0]       tx_adj;
    logic [LH_W-1:0]         lh_sat;
    logic [FIX_W-1:0]        step_sat;
    logic [HALF_W-1:0]       lh_half;
    logic                    tall;
    logic [ROW_W-1:0]        first_c;
    logic [LH_W-1:0]         endv;
    logic [ROW_W-1:0]        end_c;
    logic [HALF_W-1:0]       off_c;
    logic [PMUL_W-1:0]       pmul;

    rcts_divider #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_num),
        .denom (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign cmd.ready = in_ready;
    assign load_acc  = cmd.valid && in_ready && (op_t'(cmd.opcode) == OP_LOAD);

    assign lh_num   = NUM_W'(SCREEN_HEIGHT) << FRACTION_BITS;
    assign step_num = NUM_W'(1) << (FRACTION_BITS + int'(cfg.tex_hlog2));
    assign quot_ext = 64'(div_quot);
    assign lh_sat   = (|quot_ext[63:LH_W]) ? '1 : quot_ext[LH_W-1:0];
    assign step_sat = (|quot_ext[63:FIX_W]) ? '1 : quot_ext[FIX_W-1:0];

    // wall hit coordinate: only the fraction bits matter
    assign prod_c = $signed({1'b0, dist_reg}) * dir_reg;
    assign wc_sum = WC_W'({wpos_reg, {DIR_FRAC{1'b0}}}) + WC_W'(prod_reg);
    assign tx_raw = txp_reg[FRACTION_BITS +: TEXW_W];
    assign tx_adj = mirror_reg ? (cfg.tex_width - TEXW_W'(1) - tx_raw) : tx_raw;

    assign lh_half = lh_reg[LH_W-1:1];
    assign tall    = lh_half > HALF_W'(H_HALF);
    assign first_c = tall ? '0 : (ROW_W'(H_HALF) - ROW_W'(lh_half));
    assign endv    = LH_W'(lh_half) + LH_W'(H_HALF);
    assign end_c   = (endv > LH_W'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 2)
                                                   : ROW_W'(endv - LH_W'(1));
    assign off_c   = tall ? (lh_half - HALF_W'(H_HALF)) : '0;
    assign pmul    = PMUL_W'(off_reg) * PMUL_W'(step_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FS_IDLE:     if (load_acc) state_next = FS_PROD;
            FS_PROD:     state_next = FS_FRAC;
            FS_FRAC:     state_next = FS_TXMUL;
            FS_TXMUL:    state_next = FS_TXFIX;
            FS_TXFIX:    state_next = FS_LHWAIT;
            FS_LHWAIT:   if (div_done) state_next = FS_LHFIX;
            FS_LHFIX:    state_next = (lh_reg == '0) ? FS_POSMUL : FS_STEPWAIT;
            FS_STEPWAIT: if (div_done) state_next = FS_POSMUL;
            FS_POSMUL:   state_next = FS_PUSH;
            FS_PUSH:     if (q_wr_ready) state_next = FS_IDLE;
            default:     state_next = FS_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        q_wr_valid = 1'b0;
        div_start  = 1'b0;
        div_num    = lh_num;
        div_den    = dist_reg;
        q_wr_entry.op        = OP_LOAD;
        q_wr_entry.column    = col_reg;
        q_wr_entry.side      = side_reg;
        q_wr_entry.texel_x   = texel_reg;
        q_wr_entry.first_row = first_reg;
        q_wr_entry.end_row   = end_reg;
        q_wr_entry.step      = step_reg;
        q_wr_entry.tpos      = tpos_reg;
        case (state_reg)
            FS_IDLE:
            begin
                // row ticks go straight through; descriptor fields unused
                in_ready      = q_wr_ready;
                q_wr_valid    = cmd.valid && (op_t'(cmd.opcode) == OP_ROW);
                q_wr_entry.op = OP_ROW;
            end
            FS_PROD:
            begin
                div_start = 1'b1;
            end
            FS_LHFIX:
            begin
                div_start = (lh_reg != '0);
                div_num   = step_num;
                div_den   = lh_reg;
            end
            FS_PUSH:
            begin
                q_wr_valid = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= FS_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            FS_IDLE:
            begin
                if (load_acc)
                begin
                    col_reg  <= cmd.column_x;
                    side_reg <= cmd.hit_side;
                    dist_reg <= cmd.wall_distance;
                    if (!cmd.hit_side[1])
                    begin
                        wpos_reg   <= cmd.player_y;
                        dir_reg    <= cmd.ray_dy;
                        mirror_reg <= (cmd.ray_dx > 0);
                    end
                    else
                    begin
                        wpos_reg   <= cmd.player_x;
                        dir_reg    <= cmd.ray_dx;
                        mirror_reg <= (cmd.ray_dy < 0);
                    end
                end
            end
            FS_PROD:   prod_reg  <= prod_c[PROD_W-1:0];
            FS_FRAC:   frac_reg  <= wc_sum[WC_W-1:DIR_FRAC];
            FS_TXMUL:  txp_reg   <= TXP_W'(frac_reg) * TXP_W'(cfg.tex_width);
            FS_TXFIX:  texel_reg <= tx_adj[TEXEL_W-1:0];
            FS_LHWAIT: if (div_done) lh_reg <= lh_sat;
            FS_LHFIX:
            begin
                first_reg <= first_c;
                end_reg   <= end_c;
                off_reg   <= off_c;
                step_reg  <= '0;
            end
            FS_STEPWAIT: if (div_done) step_reg <= step_sat;
            FS_POSMUL:   tpos_reg <= pmul[FIX_W-1:0];
            default:
            begin
                tpos_reg <= tpos_reg;
            end
        endcase
    end

endmodule

// ----- sv/rcts_queue.sv -----
// Small in-order queue of descriptors and row ticks between front and back.
// Depends on rcts_pkg.
module rcts_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  rcts_pkg::entry_t  wr_entry,
    output logic              rd_valid,
    input  logic              rd_ready,
    output rcts_pkg::entry_t  rd_entry
);
    import rcts_pkg::*;

    localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    entry_t          mem_reg [Q_DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            push;
    logic            pop;

    assign wr_ready = (count_reg != CW'(Q_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (push && !pop)
                count_reg <= count_reg + CW'(1);
            else if (pop && !push)
                count_reg <= count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// ----- sv/rcts_back.sv -----
// Back end: holds the active column and turns each row tick into one pixel
// in a registered output stage. Depends on rcts_pkg.
module rcts_back #(
    parameter int SCREEN_HEIGHT = rcts_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRACTION_BITS = rcts_pkg::FRACTION_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rcts_pkg::cfg_t    cfg,
    input  logic              q_rd_valid,
    output logic              q_rd_ready,
    input  rcts_pkg::entry_t  q_rd_entry,
    rcts_pix_if.source        pix
);
    import rcts_pkg::*;

    logic               active_reg, active_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [FIX_W-1:0]   tpos_reg, tpos_next;
    logic [COL_W-1:0]   col_reg;
    logic [SIDE_W-1:0]  side_reg;
    logic [TEXEL_W-1:0] texel_reg;
    logic [ROW_W-1:0]   first_reg;
    logic [ROW_W-1:0]   end_reg;
    logic [FIX_W-1:0]   step_reg;
    logic               out_valid_reg;
    pix_t               out_reg;
    pix_t               pix_c;

    logic               pop;
    logic               is_last;
    logic [TEXEL_W:0]   hmask_w;
    logic [FIX_W-1:0]   tpos_shr;

    assign q_rd_ready = !out_valid_reg || pix.ready;
    assign pop        = q_rd_valid && q_rd_ready;

    assign hmask_w  = ((TEXEL_W + 1)'(1) << cfg.tex_hlog2) - (TEXEL_W + 1)'(1);
    assign tpos_shr = tpos_reg >> FRACTION_BITS;
    assign is_last  = {1'b0, row_reg} >= (ROW_W + 1)'(SCREEN_HEIGHT - 1);

    always_comb
    begin
        pix_c       = '0;
        active_next = active_reg;
        row_next    = row_reg;
        tpos_next   = tpos_reg;
        // a row tick with no active column gives an all-zero pixel
        if (active_reg)
        begin
            pix_c.valid_res      = 1'b1;
            pix_c.pixel_column   = col_reg;
            pix_c.pixel_row      = row_reg;
            pix_c.texture_select = side_reg;
            if (row_reg < first_reg)
            begin
                pix_c.pixel_kind  = KIND_CEILING;
                pix_c.solid_color = cfg.ceiling_color;
            end
            else if (row_reg < end_reg)
            begin
                pix_c.pixel_kind = KIND_WALL;
                pix_c.texel_x    = texel_reg;
                pix_c.texel_y    = tpos_shr[TEXEL_W-1:0] & hmask_w[TEXEL_W-1:0];
                tpos_next        = tpos_reg + step_reg;
            end
            else
            begin
                pix_c.pixel_kind  = KIND_FLOOR;
                pix_c.solid_color = cfg.floor_color;
            end
            pix_c.last_row = is_last;
            if (is_last)
                active_next = 1'b0;
            row_next = row_reg + ROW_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && q_rd_entry.op == OP_LOAD)
                active_reg <= 1'b1;
            else if (pop)
                active_reg <= active_next;

            if (pop && q_rd_entry.op == OP_ROW)
                out_valid_reg <= 1'b1;
            else if (pix.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && q_rd_entry.op == OP_LOAD)
        begin
            col_reg   <= q_rd_entry.column;
            side_reg  <= q_rd_entry.side;
            texel_reg <= q_rd_entry.texel_x;
            first_reg <= q_rd_entry.first_row;
            end_reg   <= q_rd_entry.end_row;
            step_reg  <= q_rd_entry.step;
            tpos_reg  <= q_rd_entry.tpos;
            row_reg   <= '0;
        end
        else if (pop)
        begin
            row_reg  <= row_next;
            tpos_reg <= tpos_next;
            out_reg  <= pix_c;
        end
    end

    assign pix.valid          = out_valid_reg;
    assign pix.valid_res      = out_reg.valid_res;
    assign pix.pixel_column   = out_reg.pixel_column;
    assign pix.pixel_row      = out_reg.pixel_row;
    assign pix.pixel_kind     = out_reg.pixel_kind;
    assign pix.solid_color    = out_reg.solid_color;
    assign pix.texture_select = out_reg.texture_select;
    assign pix.texel_x        = out_reg.texel_x;
    assign pix.texel_y        = out_reg.texel_y;
    assign pix.last_row       = out_reg.last_row;

endmodule

// ----- sv/raycast_column_texture_stepper.sv -----
// Raycast wall column stepper: a row request goes through the queue and its pixel
// leaves from an output register, one row per cycle sustained while pix is ready
// and no load is busy. A load runs the one-bit-per-cycle divider on N =
// max(clog2(SCREEN_HEIGHT+1), 11) + FRACTION_BITS numerator bits for the line
// height, then the texture step unless that is 0. A 2-entry queue decouples
// front/back. Reset: no column active, colors 0, texture width 64, height log2 6.
module raycast_column_texture_stepper #(
    parameter int SCREEN_HEIGHT = rcts_pkg::SCREEN_HEIGHT_DEF,
    parameter int FRACTION_BITS = rcts_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [rcts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rcts_pkg::CFG_DATA_W-1:0] cfg_data,
    rcts_cmd_if.sink                        cmd,
    rcts_pix_if.source                      pix
);
    import rcts_pkg::*;

    cfg_t   cfg_reg;
    logic   q_wr_valid;
    logic   q_wr_ready;
    entry_t q_wr_entry;
    logic   q_rd_valid;
    logic   q_rd_ready;
    entry_t q_rd_entry;

    logic [TEXW_W-1:0]  width_in;
    logic [HLOG2_W-1:0] hlog2_in;

    assign width_in = cfg_data[TEXW_W-1:0];
    assign hlog2_in = cfg_data[HLOG2_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ceiling_color <= '0;
            cfg_reg.floor_color   <= '0;
            cfg_reg.tex_width     <= TEXW_W'(TEX_WIDTH_RST);
            cfg_reg.tex_hlog2     <= HLOG2_W'(TEX_HLOG2_RST);
        end
        else if (cfg_write)
        begin
            case (reg_idx_t'(cfg_index))
                REG_CEILING:   cfg_reg.ceiling_color <= cfg_data[COLOR_W-1:0];
                REG_FLOOR:     cfg_reg.floor_color   <= cfg_data[COLOR_W-1:0];
                REG_TEX_WIDTH:
                begin
                    if (width_in == '0)
                        cfg_reg.tex_width <= TEXW_W'(1);
                    else if (width_in > TEXW_W'(TEX_WIDTH_MAX))
                        cfg_reg.tex_width <= TEXW_W'(TEX_WIDTH_MAX);
                    else
                        cfg_reg.tex_width <= width_in;
                end
                REG_TEX_HLOG2:
                begin
                    if (hlog2_in > HLOG2_W'(TEX_HLOG2_MAX))
                        cfg_reg.tex_hlog2 <= HLOG2_W'(TEX_HLOG2_MAX);
                    else
                        cfg_reg.tex_hlog2 <= hlog2_in;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    rcts_front #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .cfg        (cfg_reg),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_entry (q_wr_entry)
    );

    rcts_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_entry (q_wr_entry),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_entry (q_rd_entry)
    );

    rcts_back #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_rd_valid (q_rd_valid),
        .q_rd_ready (q_rd_ready),
        .q_rd_entry (q_rd_entry),
        .pix        (pix)
    );

    // a load request keeps the front busy for its setup
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.opcode == OP_LOAD) |=> !cmd.ready)
        else $error("front took a request right after a column load");

    // a descriptor leaving the queue never produces a pixel
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (q_rd_valid && q_rd_ready && q_rd_entry.op == OP_LOAD && pix.valid && pix.ready)
        |=> !pix.valid)
        else $error("column load produced a pixel");

    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.last_row) |-> (pix.pixel_row == ROW_W'(SCREEN_HEIGHT - 1)))
        else $error("last row flag on the wrong row");

    a_solid_texel: assert property (@(posedge clk) disable iff (!rst_n)
        (pix.valid && pix.pixel_kind != KIND_WALL) |-> (pix.texel_x == '0 && pix.texel_y == '0))
        else $error("texel coordinates on a ceiling or floor pixel");

endmodule

// ----- verif/raycast_column_texture_stepper_tb.sv -----
// Self-checking testbench for raycast_column_texture_stepper: column loads and row
// requests in, one pixel per row request out, checked against a cycle-free predictor.
// Depends on rcts_pkg, rcts_channels.sv and the stepper RTL.
`timescale 1ns / 1ps

module raycast_column_texture_stepper_tb;
    import rcts_pkg::*;

    localparam int H_ROWS = SCREEN_HEIGHT_DEF;
    localparam int FRAC = FRACTION_BITS_DEF;
    localparam longint unsigned LH_SAT = 64'hFF_FFFF;
    localparam longint unsigned STEP_SAT = 64'hFFFF_FFFF;
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASE_BUDGET = 55;
    localparam int NUM_PHASES = 6;

    typedef struct {
        op_t                     op;
        logic [COL_W-1:0]        column_x;
        logic [SIDE_W-1:0]       hit_side;
        logic [DIST_W-1:0]       wall_distance;
        logic signed [DIR_W-1:0] ray_dx;
        logic signed [DIR_W-1:0] ray_dy;
        logic [POS_W-1:0]        player_x;
        logic [POS_W-1:0]        player_y;
    } cmd_req_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rcts_cmd_if cmd_ch ();
    rcts_pix_if pix_ch ();

    raycast_column_texture_stepper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .pix       (pix_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // register copies as written (saturation applied where used)
    logic [COLOR_W-1:0] ceil_rgb;
    logic [COLOR_W-1:0] floor_rgb;
    logic [TEXW_W-1:0]  tex_width_reg;
    logic [HLOG2_W-1:0] tex_hlog2_reg;

    // column state
    logic               col_active;
    logic [COL_W-1:0]   col_x;
    logic [SIDE_W-1:0]  col_side;
    logic [TEXEL_W-1:0] col_texel_x;
    logic [ROW_W-1:0]   wall_first;
    logic [ROW_W-1:0]   wall_end;
    logic [ROW_W-1:0]   row_ctr;
    logic [FIX_W-1:0]   tex_pos;
    logic [FIX_W-1:0]   tex_step;

    cmd_req_t req_backlog[$];
    pix_t     pixels_due[$];
    int       mismatches = 0;

    function automatic int unsigned hlog2_in_use();
        return (tex_hlog2_reg > TEX_HLOG2_MAX) ? TEX_HLOG2_MAX : tex_hlog2_reg;
    endfunction

    function automatic void setup_column(cmd_req_t r);
        longint unsigned lh, first, endv, frac, tx, step, off, width, pos;
        longint dist_s, dir_s, wcoord;
        logic mirror;
        if (r.wall_distance == '0)
            lh = LH_SAT;
        else
        begin
            lh = (longint'(H_ROWS) << FRAC) / longint'(r.wall_distance);
            if (lh > LH_SAT)
                lh = LH_SAT;
        end
        first = (lh / 2 > H_ROWS / 2) ? 0 : H_ROWS / 2 - lh / 2;
        endv = lh / 2 + H_ROWS / 2;
        if (endv > H_ROWS)
            endv = H_ROWS - 1;

        dist_s = r.wall_distance;
        if (r.hit_side < 2)
        begin
            pos = r.player_y;
            dir_s = r.ray_dy;
            mirror = r.ray_dx > 0;
        end
        else
        begin
            pos = r.player_x;
            dir_s = r.ray_dx;
            mirror = r.ray_dy < 0;
        end
        wcoord = (longint'(pos) << DIR_FRAC) + dist_s * dir_s;
        frac = wcoord[DIR_FRAC +: FRAC];

        width = (tex_width_reg == '0) ? 1 :
                (tex_width_reg > TEX_WIDTH_MAX) ? TEX_WIDTH_MAX : tex_width_reg;
        tx = (frac * width) >> FRAC;
        if (mirror)
            tx = width - tx - 1;

        if (lh == 0)
            step = 0;
        else
        begin
            step = ((64'd1 << hlog2_in_use()) << FRAC) / lh;
            if (step > STEP_SAT)
                step = STEP_SAT;
        end
        off = first + lh / 2 - H_ROWS / 2;

        col_active = 1'b1;
        col_x = r.column_x;
        col_side = r.hit_side;
        col_texel_x = tx[TEXEL_W-1:0];
        wall_first = first[ROW_W-1:0];
        wall_end = ROW_W'(endv - 1);
        row_ctr = '0;
        tex_step = step[FIX_W-1:0];
        tex_pos = FIX_W'(off * step);
    endfunction

    function automatic pix_t trace_row();
        pix_t p;
        logic [ROW_W-1:0] r;
        p = '0;
        if (!col_active)
            return p;
        r = row_ctr;
        p.valid_res = 1'b1;
        p.pixel_column = col_x;
        p.pixel_row = r;
        p.texture_select = col_side;
        if (r < wall_first)
        begin
            p.pixel_kind = KIND_CEILING;
            p.solid_color = ceil_rgb;
        end
        else if (r < wall_end)
        begin
            p.pixel_kind = KIND_WALL;
            p.texel_x = col_texel_x;
            // row fetched from the position before it advances
            p.texel_y = TEXEL_W'((tex_pos >> FRAC) & ((32'd1 << hlog2_in_use()) - 1));
            tex_pos = tex_pos + tex_step;
        end
        else
        begin
            p.pixel_kind = KIND_FLOOR;
            p.solid_color = floor_rgb;
        end
        if (r >= H_ROWS - 1)
        begin
            p.last_row = 1'b1;
            col_active = 1'b0;
        end
        row_ctr = r + 1'b1;
        return p;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic cmd_req_t random_req(op_t op);
        cmd_req_t r;
        int unsigned pick;
        r.op = op;
        r.column_x = COL_W'($urandom);
        r.hit_side = SIDE_W'($urandom);
        r.ray_dx = DIR_W'($urandom);
        r.ray_dy = DIR_W'($urandom);
        r.player_x = POS_W'($urandom);
        r.player_y = POS_W'($urandom);
        if ($urandom_range(0, 9) == 0)
            r.ray_dx = '0;
        if ($urandom_range(0, 9) == 0)
            r.ray_dy = '0;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            r.wall_distance = '0;
        else if (pick < 20)
            r.wall_distance = DIST_W'($urandom_range(1, 4095));
        else if (pick < 65)
            r.wall_distance = DIST_W'($urandom_range(16384, 131072)); // 0.5-4x screen height
        else
            r.wall_distance = DIST_W'($urandom);
        return r;
    endfunction

    function automatic cmd_req_t make_load(int col, int side, int span, int rdx, int rdy,
                                           int px, int py);
        cmd_req_t r;
        r.op = OP_LOAD;
        r.column_x = COL_W'(col);
        r.hit_side = SIDE_W'(side);
        r.wall_distance = DIST_W'(span);
        r.ray_dx = DIR_W'(rdx);
        r.ray_dy = DIR_W'(rdy);
        r.player_x = POS_W'(px);
        r.player_y = POS_W'(py);
        return r;
    endfunction

    // request driver: bursts of random length, random gaps between them
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge clk)
    begin
        cmd_req_t cur;
        if (rst_n && (!cmd_ch.valid || cmd_ch.ready))
        begin
            if (gap_left > 0 || req_backlog.size() == 0)
            begin
                if (gap_left > 0)
                    gap_left--;
                cmd_ch.valid <= 1'b0;
            end
            else
            begin
                cur = req_backlog.pop_front();
                cmd_ch.opcode <= cur.op;
                cmd_ch.column_x <= cur.column_x;
                cmd_ch.hit_side <= cur.hit_side;
                cmd_ch.wall_distance <= cur.wall_distance;
                cmd_ch.ray_dx <= cur.ray_dx;
                cmd_ch.ray_dy <= cur.ray_dy;
                cmd_ch.player_x <= cur.player_x;
                cmd_ch.player_y <= cur.player_y;
                cmd_ch.valid <= 1'b1;
                if (burst_left > 1)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // pixel receiver stalls on a random 16-bit ready mask, reshuffled when the tick wraps
    logic [15:0] ready_mask = 16'hFFFF;
    logic [4:0]  stall_tick = '0;

    always @(posedge clk)
    begin
        int unsigned pick;
        if (rst_n)
        begin
            if (stall_tick == '0)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 35)
                    ready_mask = 16'hFFFF;
                else if (pick < 50)
                    ready_mask = 16'($urandom & $urandom);
                else
                    ready_mask = 16'($urandom);
                if (ready_mask == '0)
                    ready_mask = 16'h0001;
            end
            pix_ch.ready <= ready_mask[stall_tick[3:0]];
            stall_tick++;
        end
    end

    // accepted requests feed the predictor
    always @(posedge clk)
    begin
        cmd_req_t req;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            req.op = op_t'(cmd_ch.opcode);
            req.column_x = cmd_ch.column_x;
            req.hit_side = cmd_ch.hit_side;
            req.wall_distance = cmd_ch.wall_distance;
            req.ray_dx = cmd_ch.ray_dx;
            req.ray_dy = cmd_ch.ray_dy;
            req.player_x = cmd_ch.player_x;
            req.player_y = cmd_ch.player_y;
            if (req.op == OP_LOAD)
                setup_column(req);
            else
                pixels_due.push_back(trace_row());
        end
    end

    always @(posedge clk)
    begin
        pix_t want;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            if (pixels_due.size() == 0)
            begin
                $error("unexpected pixel: column %0d row %0d", pix_ch.pixel_column,
                       pix_ch.pixel_row);
                mismatches++;
            end
            else
            begin
                want = pixels_due.pop_front();
                check_field("valid_res", want.valid_res, pix_ch.valid_res);
                check_field("pixel_column", want.pixel_column, pix_ch.pixel_column);
                check_field("pixel_row", want.pixel_row, pix_ch.pixel_row);
                check_field("pixel_kind", want.pixel_kind, pix_ch.pixel_kind);
                check_field("solid_color", want.solid_color, pix_ch.solid_color);
                check_field("texture_select", want.texture_select, pix_ch.texture_select);
                check_field("texel_x", want.texel_x, pix_ch.texel_x);
                check_field("texel_y", want.texel_y, pix_ch.texel_y);
                check_field("last_row", want.last_row, pix_ch.last_row);
            end
        end
    end

    task automatic program_regs(logic [COLOR_W-1:0] c_rgb, logic [COLOR_W-1:0] f_rgb,
                                logic [TEXW_W-1:0] width, logic [HLOG2_W-1:0] hlog2);
        reg_idx_t idx;
        logic [CFG_DATA_W-1:0] vals[4];
        vals[0] = c_rgb;
        vals[1] = f_rgb;
        vals[2] = CFG_DATA_W'(width);
        vals[3] = CFG_DATA_W'(hlog2);
        for (int i = 0; i < 4; i++)
        begin
            idx = reg_idx_t'(i);
            @(posedge clk);
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data <= vals[i];
        end
        @(posedge clk);
        cfg_write <= 1'b0;
        ceil_rgb = c_rgb;
        floor_rgb = f_rgb;
        tex_width_reg = width;
        tex_hlog2_reg = hlog2;
    endtask

    // a trailing load yields no pixel, so give the divider time to finish
    task automatic wait_drained();
        while (req_backlog.size() != 0 || cmd_ch.valid || pixels_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random(int budget, bit force_full);
        int queued;
        int n;
        int rows;
        int unsigned pick;
        bit full;
        queued = 0;
        while (queued < budget)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
            begin
                // stray rows: continue a column, or hit an idle stepper
                n = $urandom_range(1, 3);
                repeat (n) req_backlog.push_back(random_req(OP_ROW));
            end
            else
            begin
                req_backlog.push_back(random_req(OP_LOAD));
                n = 1;
                if (pick < 18)
                begin
                    req_backlog.push_back(random_req(OP_LOAD));
                    n++;
                end
                full = force_full || pick >= 95;
                force_full = 1'b0;
                // a full column runs a few rows past the end
                rows = full ? H_ROWS + $urandom_range(1, 3) : $urandom_range(1, 80);
                repeat (rows) req_backlog.push_back(random_req(OP_ROW));
                n += rows;
            end
            queued += n;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        cmd_ch.valid = 1'b0;
        cmd_ch.opcode = OP_LOAD;
        cmd_ch.column_x = '0;
        cmd_ch.hit_side = '0;
        cmd_ch.wall_distance = '0;
        cmd_ch.ray_dx = '0;
        cmd_ch.ray_dy = '0;
        cmd_ch.player_x = '0;
        cmd_ch.player_y = '0;
        pix_ch.ready = 1'b0;

        ceil_rgb = '0;
        floor_rgb = '0;
        tex_width_reg = TEXW_W'(TEX_WIDTH_RST);
        tex_hlog2_reg = HLOG2_W'(TEX_HLOG2_RST);
        col_active = 1'b0;
        col_x = '0;
        col_side = '0;
        col_texel_x = '0;
        wall_first = '0;
        wall_end = '0;
        row_ctr = '0;
        tex_pos = '0;
        tex_step = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, on reset register values
        req_backlog.push_back(random_req(OP_ROW));          // no column yet
        req_backlog.push_back(make_load(4095, 0, 0, 32767, -32768, 0, 24'hFFFFFF));
        repeat (3) req_backlog.push_back(random_req(OP_ROW));
        req_backlog.push_back(make_load(0, 3, 24'hFFFFFF, -32768, 32767, 24'hFFFFFF, 0));
        repeat (2) req_backlog.push_back(random_req(OP_ROW));
        req_backlog.push_back(make_load(17, 1, 65536, 0, 0, 24'h123456, 24'h00FFFF));
        repeat (2) req_backlog.push_back(random_req(OP_ROW));
        req_backlog.push_back(make_load(2048, 2, 1, -1, -1, 24'h7FFFFF, 24'h800000));
        req_backlog.push_back(random_req(OP_ROW));
        req_backlog.push_back(make_load(123, 2, 32768, 16384, 1, 24'h018000, 0));
        repeat (3) req_backlog.push_back(random_req(OP_ROW));
        req_backlog.push_back(make_load(9, 1, 98304, 1, -16384, 0, 24'h02C000));
        repeat (2) req_backlog.push_back(random_req(OP_ROW));
        wait_drained();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: program_regs(COLOR_W'($urandom), COLOR_W'($urandom), TEXW_W'(1),
                                HLOG2_W'(0));
                1: program_regs(24'hFFFFFF, 24'h000000, TEXW_W'(TEX_WIDTH_MAX),
                                HLOG2_W'(TEX_HLOG2_MAX));
                2: program_regs(COLOR_W'($urandom), COLOR_W'($urandom), TEXW_W'(0),
                                4'hF);                                   // both saturate
                3: program_regs(COLOR_W'($urandom), COLOR_W'($urandom), 11'h7FF,
                                HLOG2_W'(11));                           // both saturate
                4: program_regs(COLOR_W'($urandom), COLOR_W'($urandom),
                                TEXW_W'($urandom_range(1, TEX_WIDTH_MAX)),
                                HLOG2_W'($urandom_range(0, TEX_HLOG2_MAX)));
                default: program_regs(24'h000000, 24'hFFFFFF, TEXW_W'(TEX_WIDTH_RST),
                                      HLOG2_W'(TEX_HLOG2_RST));
            endcase
            queue_random(PHASE_BUDGET, ph == 0);
            wait_drained();
        end

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
